[src/bps_pkg.sv]
// Package for the bicubic plane scaler: constants, register indexes and sizes.
// Used by every module of the block; depends on nothing.
`default_nettype none
package bps_pkg;
   localparam int MaxWidthDefault  = 256;
   localparam int MaxHeightDefault = 256;
   localparam int FracBitsDefault  = 8;
   localparam int CsrIdxWidth      = 3;
   localparam int PixelWidth       = 8;
   localparam int PosWidth         = 12;
   localparam int SizeWidth        = 9;
   localparam int StepWidth        = 25;
   localparam logic [CsrIdxWidth-1:0] RegSrcWidth  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegSrcHeight = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegStepX     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegStepY     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegSignMode  = 3'd4;
   localparam logic CmdLoad    = 1'b0;
   localparam logic CmdCompute = 1'b1;
endpackage
`default_nettype wire

[src/bicubic_plane_scaler.sv]
// Bicubic plane scaler top level: configuration registers, frame store and sequencer.
// A load word is accepted every cycle while idle. A compute word makes sixteen
// frame-store reads (four a row) and five passes through the shared cubic unit (four rows,
// then one column); no new word is accepted until its result is in the output register.
// A finished result waits in the output register; a later result waits for it to free.
// Reset is synchronous and restores control registers; frame-store contents stay undefined.
`default_nettype none
module bicubic_plane_scaler #(
   parameter int MAX_WIDTH  = bps_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = bps_pkg::MaxHeightDefault,
   parameter int FRAC_BITS  = bps_pkg::FracBitsDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bps_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [31:0]                        csr_data,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_cmd,
   input  wire logic [bps_pkg::PosWidth-1:0]       req_pos_x,
   input  wire logic [bps_pkg::PosWidth-1:0]       req_pos_y,
   input  wire logic [bps_pkg::PixelWidth-1:0]     req_pixel_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [bps_pkg::PixelWidth-1:0]          rsp_pixel_out
);
   import bps_pkg::*;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = XW + YW;
   localparam int ProdW = StepWidth + PosWidth;
   localparam int IntW = ProdW - 16;
   localparam logic [2:0] StIdle = 3'd0, StMul = 3'd1, StRead = 3'd2, StRow = 3'd3,
      StCol = 3'd4, StOut = 3'd5, StWait = 3'd6;

   logic [SizeWidth-1:0] width_ff, height_ff;
   logic [StepWidth-1:0] stepx_ff, stepy_ff;
   logic sign_ff;
   logic [2:0] state_ff;
   logic [ProdW-1:0] sx_ff, sy_ff;
   logic [PosWidth-1:0] px_ff, py_ff;
   logic [3:0] tap_ff;
   logic [2:0] row_ff;
   logic rd_pend_ff;
   logic signed [9:0] taps_ff [4];
   logic signed [9:0] cols_ff [4];
   logic [PixelWidth-1:0] mem [2**AW];
   logic [PixelWidth-1:0] rdata_ff;
   logic cu_start, cu_done;
   logic signed [9:0] cu_res;
   logic [FRAC_BITS-1:0] fx, fy, cu_frac;
   logic [IntW-1:0] ix, iy;
   logic [IntW+1:0] tc, tr;
   logic [XW:0] wlim;
   logic [YW:0] hlim;
   logic [XW-1:0] col;
   logic [YW-1:0] row;
   logic signed [9:0] tapv;
   logic out_load;

   assign csr_ready = state_ff == StIdle;
   assign req_ready = state_ff == StIdle;
   assign ix = sx_ff[ProdW-1:16];
   assign iy = sy_ff[ProdW-1:16];
   assign fx = sx_ff[15 -: FRAC_BITS];
   assign fy = sy_ff[15 -: FRAC_BITS];

   always_comb begin
      wlim = width_ff == 0 ? (XW+1)'(1) :
         (width_ff > MAX_WIDTH ? (XW+1)'(MAX_WIDTH) : (XW+1)'(width_ff));
      hlim = height_ff == 0 ? (YW+1)'(1) :
         (height_ff > MAX_HEIGHT ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(height_ff));
      tc = {2'b0, ix} + (IntW+2)'(tap_ff[1:0]);
      tr = {2'b0, iy} + (IntW+2)'(row_ff[1:0]);
      col = tc == 0 ? '0 : (tc - 1 > (IntW+2)'(wlim - 1) ? XW'(wlim - 1) : XW'(tc - 1));
      row = tr == 0 ? '0 : (tr - 1 > (IntW+2)'(hlim - 1) ? YW'(hlim - 1) : YW'(tr - 1));
      tapv = sign_ff ? 10'(signed'(rdata_ff)) : 10'({2'b0, rdata_ff});
      cu_frac = state_ff == StCol ? fy : fx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256; height_ff <= 9'd256;
         stepx_ff <= 25'd65536; stepy_ff <= 25'd65536; sign_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegSrcWidth:  width_ff <= csr_data[SizeWidth-1:0];
            RegSrcHeight: height_ff <= csr_data[SizeWidth-1:0];
            RegStepX:     stepx_ff <= csr_data[StepWidth-1:0];
            RegStepY:     stepy_ff <= csr_data[StepWidth-1:0];
            RegSignMode:  sign_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && req_cmd == CmdLoad &&
          req_pos_x < MAX_WIDTH && req_pos_y < MAX_HEIGHT)
         mem[{YW'(req_pos_y), XW'(req_pos_x)}] <= req_pixel_in;
      rdata_ff <= mem[{row, col}];
   end

   assign cu_start = (state_ff == StRead && rd_pend_ff && tap_ff == 4'd4) ||
      (state_ff == StCol && !rd_pend_ff);

   assign out_load = ((state_ff == StCol && cu_done) || state_ff == StOut) &&
      (!rsp_valid || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle; rsp_valid <= 1'b0; rd_pend_ff <= 1'b0;
         tap_ff <= '0; row_ff <= '0;
      end else begin
         if (out_load) begin
            rsp_pixel_out <= cu_res[7:0]; rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            StIdle: if (req_valid && req_cmd == CmdCompute) begin
               px_ff <= req_pos_x; py_ff <= req_pos_y; state_ff <= StMul;
            end
            StMul: begin
               sx_ff <= stepx_ff * px_ff; sy_ff <= stepy_ff * py_ff;
               tap_ff <= '0; row_ff <= '0; rd_pend_ff <= 1'b0;
               state_ff <= StRead;
            end
            StRead: begin
               if (rd_pend_ff) taps_ff[tap_ff[1:0] - 2'd1] <= tapv;
               if (tap_ff == 4'd4 && rd_pend_ff) begin
                  state_ff <= StRow; rd_pend_ff <= 1'b0;
               end else begin
                  rd_pend_ff <= 1'b1; tap_ff <= tap_ff + 4'd1;
               end
            end
            StRow: if (cu_done) begin
               cols_ff[row_ff[1:0]] <= cu_res;
               tap_ff <= '0;
               if (row_ff == 3'd3) begin
                  state_ff <= StCol; rd_pend_ff <= 1'b0;
               end else begin
                  row_ff <= row_ff + 3'd1; state_ff <= StRead;
               end
            end
            StCol: begin
               rd_pend_ff <= 1'b1;
               if (cu_done) state_ff <= out_load ? StIdle : StOut;
            end
            StOut: if (out_load) begin
               state_ff <= StIdle;
            end
            default: state_ff <= StIdle;
         endcase
      end
   end

   bps_cubic_unit #(.FRAC_BITS(FRAC_BITS)) u_cubic (
      .clock(clock), .reset(reset), .start(cu_start), .signed_mode(sign_ff),
      .frac(cu_frac),
      .p0(state_ff == StCol ? cols_ff[0] : taps_ff[0]),
      .p1(state_ff == StCol ? cols_ff[1] : taps_ff[1]),
      .p2(state_ff == StCol ? cols_ff[2] : taps_ff[2]),
      .p3(state_ff == StCol ? cols_ff[3] : (tap_ff == 4'd4 ? tapv : taps_ff[3])),
      .done(cu_done), .result(cu_res)
   );

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel_out)) else $error("result changed");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_cu_start: assert property (@(posedge clock) disable iff (reset)
      cu_start |-> state_ff == StRead || state_ff == StCol) else $error("bad start");
endmodule
`default_nettype wire

[src/bps_cubic_unit.sv]
// Shared Catmull-Rom cubic unit: three Horner multiply steps, then scale and saturate.
// Depends on bps_pkg; started by the sequencer in the top level.
`default_nettype none
module bps_cubic_unit #(
   parameter int FRAC_BITS = bps_pkg::FracBitsDefault
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           signed_mode,
   input  wire logic [FRAC_BITS-1:0]           frac,
   input  wire logic signed [9:0]              p0,
   input  wire logic signed [9:0]              p1,
   input  wire logic signed [9:0]              p2,
   input  wire logic signed [9:0]              p3,
   output logic                                done,
   output logic signed [9:0]                   result
);
   import bps_pkg::*;
   localparam int AccWidth = 3 * FRAC_BITS + 16;
   localparam int DenShift = 3 * FRAC_BITS + 1;
   logic [1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic signed [AccWidth-1:0] acc_ff, acc_in;
   logic signed [13:0] cb_ff, cc_ff;
   logic signed [9:0] p1_ff;
   logic signed [AccWidth-1:0] addend, prod, total, quo;
   logic signed [AccWidth-1:0] den_m1;
   logic signed [9:0] sat;

   always_comb begin
      addend = '0;
      unique case (step_ff)
         2'd0: addend = AccWidth'(cb_ff) <<< FRAC_BITS;
         2'd1: addend = AccWidth'(cc_ff) <<< (2 * FRAC_BITS);
         default: addend = '0;
      endcase
      prod = acc_ff * $signed({1'b0, frac});
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in = AccWidth'(13'sd3 * (p1 - p2) + p3 - p0);
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = prod + addend;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) busy_in = 1'b0;
      end
      den_m1 = (AccWidth'(1) <<< DenShift) - AccWidth'(1);
      total = (AccWidth'(p1_ff) <<< DenShift) + acc_ff;
      quo = (total + (total < 0 ? den_m1 : AccWidth'(0))) >>> DenShift;
      if (signed_mode) begin
         sat = quo > 127 ? 10'sd127 : (quo < -127 ? -10'sd127 : quo[9:0]);
      end else begin
         sat = quo > 255 ? 10'sd255 : (quo < 0 ? 10'sd0 : quo[9:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
         done <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done <= busy_ff && step_ff == 2'd2;
      end
      acc_ff <= acc_in;
      if (start) begin
         cb_ff <= 14'sd2 * p0 - 14'sd5 * p1 + 14'sd4 * p2 - p3;
         cc_ff <= 14'(p2 - p0);
         p1_ff <= p1;
      end
   end

   assign result = sat;
endmodule
`default_nettype wire
